@@ design/ftpf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the five-tuple rule packet filter: transfer payload types, rule record,
// protocol and class codes, and the sequencer's control store.
// No dependencies.

package ftpf_pkg;

    // Table size default
    localparam int RULE_COUNT_DEF = 8;

    // Field codes
    localparam logic       OP_WRITE    = 1'b0;
    localparam logic       OP_CLASSIFY = 1'b1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [1:0] CLASS_TCP   = 2'd0;
    localparam logic [1:0] CLASS_UDP   = 2'd1;

    typedef logic [2:0] t_slot;

    // Input transfer payload
    typedef struct packed {
        logic        opcode;
        logic [2:0]  rule_slot;
        logic        rule_enable;
        logic        direction;
        logic [1:0]  rule_class;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        src_port_wild;
        logic        dst_port_wild;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic  drop;
        t_slot hit_slot;
    } t_out_item;

    // One stored rule, valid mark kept apart in flip-flops
    typedef struct packed {
        logic        direction;
        logic [1:0]  rule_class;
        logic        src_any;
        logic        dst_any;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_rule;

    // Sequencer step addresses
    typedef enum logic [2:0] {
        ST_FETCH,
        ST_DISPATCH,
        ST_PRIME,
        ST_SCAN,
        ST_EMIT,
        ST_WRITE
    } t_step;

    // Jump conditions
    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_IN_XFER,
        CND_WRITE,
        CND_OTHER,
        CND_DONE,
        CND_OUT_FREE
    } t_cond;

    // Control word: on a true condition go to target, else hold or advance
    typedef struct packed {
        logic  accept;
        logic  clr;
        logic  rd;
        logic  eval;
        logic  emit;
        logic  wr;
        t_cond cond;
        t_step target;
        logic  hold;
    } t_uop;

    // Control store
    function automatic t_uop ucode(input t_step step);
        t_uop u;
        u = '{accept: 1'b0, clr: 1'b0, rd: 1'b0, eval: 1'b0, emit: 1'b0, wr: 1'b0,
              cond: CND_ALWAYS, target: ST_FETCH, hold: 1'b0};
        unique case (step)
            ST_FETCH: begin
                u.accept = 1'b1;
                u.cond   = CND_IN_XFER;
                u.target = ST_DISPATCH;
                u.hold   = 1'b1;
            end
            ST_DISPATCH: begin
                u.clr    = 1'b1;
                u.cond   = CND_WRITE;
                u.target = ST_WRITE;
            end
            ST_PRIME: begin
                u.rd     = 1'b1;
                u.cond   = CND_OTHER;
                u.target = ST_EMIT;
            end
            ST_SCAN: begin
                u.rd     = 1'b1;
                u.eval   = 1'b1;
                u.cond   = CND_DONE;
                u.target = ST_EMIT;
                u.hold   = 1'b1;
            end
            ST_EMIT: begin
                u.emit   = 1'b1;
                u.cond   = CND_OUT_FREE;
                u.target = ST_FETCH;
                u.hold   = 1'b1;
            end
            ST_WRITE: begin
                u.wr     = 1'b1;
                u.cond   = CND_ALWAYS;
                u.target = ST_FETCH;
            end
            default: begin
                u.cond   = CND_ALWAYS;
                u.target = ST_FETCH;
            end
        endcase
        return u;
    endfunction

endpackage

@@ design/five_tuple_rule_packet_filter.sv @@
`timescale 1ns / 1ps
// Top level of the five-tuple rule packet filter: microcoded sequencer, rule memory
// with registered read, valid flags and output register. Depends on ftpf_pkg.
//
//   channel | direction | handshake                  | payload
//   in      | to block  | i_in_valid / o_in_stall     | i_in  (ftpf_pkg::t_in_item)
//   out     | from block| o_out_valid / i_out_stall   | o_out (ftpf_pkg::t_out_item)
//
// A rule write returns to fetch through the dispatch and write steps. A classify
// passes dispatch, prime, scan (which reads the rule memory one rule at a time, at most
// RULE_COUNT rules, up to the first hit) and emit; other protocols skip the scan.
// Reset clears the sequencer, the rule valid flags and the output valid; rule
// memory contents stay undefined until written.
// A stalled result sits in the output register; the block stalls its input only
// while an item is in work or the finished result cannot be placed.

module five_tuple_rule_packet_filter #(
    parameter int RULE_COUNT = ftpf_pkg::RULE_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ftpf_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ftpf_pkg::t_out_item o_out
);

    localparam int IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int CNT_W = $clog2(RULE_COUNT + 1);

    ftpf_pkg::t_step     r_step;
    ftpf_pkg::t_step     n_step;
    ftpf_pkg::t_uop      uop;
    ftpf_pkg::t_in_item  r_item;
    ftpf_pkg::t_rule     r_mem [RULE_COUNT];
    ftpf_pkg::t_rule     r_rd_rule;
    logic                r_rd_valid;
    logic [RULE_COUNT-1:0] r_valid;
    logic [CNT_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_eval_idx;
    logic                r_drop;
    ftpf_pkg::t_slot     r_hit;
    logic                r_out_valid;
    ftpf_pkg::t_out_item r_out;

    logic             in_xfer;
    logic             take;
    logic             is_l4;
    logic [1:0]       want_class;
    logic             src_fit;
    logic             dst_fit;
    logic             sport_fit;
    logic             dport_fit;
    logic             rule_hit;
    logic             last;
    logic             rd_ok;
    logic [IDX_W-1:0] rd_addr;
    logic             slot_ok;
    logic [IDX_W-1:0] wr_addr;
    logic             out_free;
    ftpf_pkg::t_rule  wr_rule;

    // Decode the current control word
    assign uop        = ftpf_pkg::ucode(r_step);
    assign o_in_stall = !uop.accept;
    assign in_xfer    = i_in_valid && uop.accept;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Match the registered rule against the held header
    assign is_l4      = (r_item.ip_protocol == ftpf_pkg::PROTO_TCP)
                     || (r_item.ip_protocol == ftpf_pkg::PROTO_UDP);
    assign want_class = (r_item.ip_protocol == ftpf_pkg::PROTO_TCP)
                      ? ftpf_pkg::CLASS_TCP : ftpf_pkg::CLASS_UDP;
    assign src_fit    = (r_item.src_addr == 32'd0) || (r_rd_rule.src_addr == 32'd0)
                     || (r_item.src_addr == r_rd_rule.src_addr);
    assign dst_fit    = (r_item.dst_addr == 32'd0) || (r_rd_rule.dst_addr == 32'd0)
                     || (r_item.dst_addr == r_rd_rule.dst_addr);
    assign sport_fit  = r_rd_rule.src_any || (r_rd_rule.src_port == r_item.src_port);
    assign dport_fit  = r_rd_rule.dst_any || (r_rd_rule.dst_port == r_item.dst_port);
    assign rule_hit   = r_rd_valid && (r_rd_rule.direction == r_item.direction)
                     && (r_rd_rule.rule_class == want_class)
                     && src_fit && dst_fit && sport_fit && dport_fit;
    assign last       = (r_eval_idx == IDX_W'(RULE_COUNT - 1));

    // Read and write addresses
    assign rd_ok   = uop.rd && (r_idx < CNT_W'(RULE_COUNT));
    assign rd_addr = r_idx[IDX_W-1:0];
    assign slot_ok = (int'(r_item.rule_slot) < RULE_COUNT);
    assign wr_addr = IDX_W'(r_item.rule_slot);

    // Pack the rule record from the held write item
    always_comb begin
        wr_rule.direction  = r_item.direction;
        wr_rule.rule_class = r_item.rule_class;
        wr_rule.src_any    = r_item.src_port_wild;
        wr_rule.dst_any    = r_item.dst_port_wild;
        wr_rule.src_addr   = r_item.src_addr;
        wr_rule.dst_addr   = r_item.dst_addr;
        wr_rule.src_port   = r_item.src_port;
        wr_rule.dst_port   = r_item.dst_port;
    end

    // Select the next step
    always_comb begin
        take = 1'b0;
        unique case (uop.cond)
            ftpf_pkg::CND_ALWAYS:   take = 1'b1;
            ftpf_pkg::CND_IN_XFER:  take = in_xfer;
            ftpf_pkg::CND_WRITE:    take = (r_item.opcode == ftpf_pkg::OP_WRITE);
            ftpf_pkg::CND_OTHER:    take = !is_l4;
            ftpf_pkg::CND_DONE:     take = rule_hit || last;
            ftpf_pkg::CND_OUT_FREE: take = out_free;
            default:                take = 1'b0;
        endcase
        if (take) begin
            n_step = uop.target;
        end else if (uop.hold) begin
            n_step = r_step;
        end else begin
            n_step = ftpf_pkg::t_step'(3'(r_step) + 3'd1);
        end
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ftpf_pkg::ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in;
        end
    end

    // Rule memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (uop.wr && slot_ok) begin
            r_mem[wr_addr] <= wr_rule;
        end
        if (rd_ok) begin
            r_rd_rule  <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
            r_eval_idx <= rd_addr;
        end
    end

    // Valid flags and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx   <= '0;
        end else begin
            if (uop.wr && slot_ok) begin
                r_valid[wr_addr] <= r_item.rule_enable;
            end
            if (uop.clr) begin
                r_idx <= '0;
            end else if (rd_ok) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // Collect the verdict
    always_ff @(posedge i_clk) begin
        if (uop.clr) begin
            r_drop <= 1'b0;
            r_hit  <= '0;
        end else if (uop.eval && rule_hit) begin
            r_drop <= 1'b1;
            r_hit  <= ftpf_pkg::t_slot'(r_eval_idx);
        end
    end

    // Output register: load on emit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uop.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uop.emit && out_free) begin
            r_out.drop     <= r_drop;
            r_out.hit_slot <= r_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ design/ftpf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the five-tuple rule packet filter and its bind.
// Depends on ftpf_pkg and five_tuple_rule_packet_filter.

module ftpf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input ftpf_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ftpf_pkg::t_out_item o_out
);

    // Hold a stalled result
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result changed while stalled");

    // Accept verdict never names a rule
    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.drop |-> o_out.hit_slot == 3'd0)
        else $error("accept result with nonzero hit slot");

    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on back-to-back cycles");

    // Rule write causes no result right after its transfer
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.opcode == ftpf_pkg::OP_WRITE)
        |=> !$rose(o_out_valid))
        else $error("result raised after a rule write");

endmodule

bind five_tuple_rule_packet_filter ftpf_checker u_ftpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for five_tuple_rule_packet_filter: queue-fed driver, output monitor and an
// internal ACL predictor, checked with directed and random rule writes and headers.
// Depends on ftpf_pkg and the filter RTL.

module testbench;

    localparam int ACL_DEPTH = ftpf_pkg::RULE_COUNT_DEF;

    // Predicted rule state
    typedef struct packed {
        logic        active;
        logic        dir;
        logic [1:0]  cls;
        logic        src_any;
        logic        dst_any;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_acl_entry;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    ftpf_pkg::t_in_item  i_in = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ftpf_pkg::t_out_item o_out;

    t_acl_entry          acl_rules [ACL_DEPTH];
    ftpf_pkg::t_in_item  last_rule_write [8];
    ftpf_pkg::t_in_item  pending_items [$];
    ftpf_pkg::t_out_item expected_verdicts [$];
    int                  mismatch_count = 0;
    int                  send_gap_pct = 10;
    int                  recv_stall_pct = 85;

    five_tuple_rule_packet_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    // Address wildcard: zero on either side matches anything
    function automatic logic addr_fits(input logic [31:0] pkt, input logic [31:0] rule_addr);
        return (pkt == '0) || (rule_addr == '0) || (pkt == rule_addr);
    endfunction

    // First-match scan over the predicted rule set
    function automatic ftpf_pkg::t_out_item classify_header(input ftpf_pkg::t_in_item h);
        ftpf_pkg::t_out_item verdict;
        logic [1:0]          want_class;
        t_acl_entry          r;
        verdict = '0;
        if (h.ip_protocol == ftpf_pkg::PROTO_TCP || h.ip_protocol == ftpf_pkg::PROTO_UDP) begin
            want_class = (h.ip_protocol == ftpf_pkg::PROTO_TCP) ? ftpf_pkg::CLASS_TCP
                                                                : ftpf_pkg::CLASS_UDP;
            for (int k = 0; k < ACL_DEPTH; k++) begin
                r = acl_rules[k];
                if (r.active && r.dir == h.direction && r.cls == want_class &&
                    addr_fits(h.src_addr, r.src_addr) && addr_fits(h.dst_addr, r.dst_addr) &&
                    (r.src_any || r.src_port == h.src_port) &&
                    (r.dst_any || r.dst_port == h.dst_port)) begin
                    verdict.drop     = 1'b1;
                    verdict.hit_slot = ftpf_pkg::t_slot'(k);
                    break;
                end
            end
        end
        return verdict;
    endfunction

    // Apply one accepted transfer to the predicted state
    function automatic void apply_transfer(input ftpf_pkg::t_in_item h);
        if (h.opcode == ftpf_pkg::OP_WRITE) begin
            if (int'(h.rule_slot) < ACL_DEPTH) begin
                acl_rules[h.rule_slot] = '{active: h.rule_enable, dir: h.direction,
                    cls: h.rule_class, src_any: h.src_port_wild, dst_any: h.dst_port_wild,
                    src_addr: h.src_addr, dst_addr: h.dst_addr,
                    src_port: h.src_port, dst_port: h.dst_port};
            end
        end else begin
            expected_verdicts.push_back(classify_header(h));
        end
    endfunction

    function automatic ftpf_pkg::t_in_item random_item();
        logic [127:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom()};
        return ftpf_pkg::t_in_item'(bits[$bits(ftpf_pkg::t_in_item)-1:0]);
    endfunction

    // Enqueue and remember the last write per slot for header generation
    function automatic void queue_item(input ftpf_pkg::t_in_item h);
        if (h.opcode == ftpf_pkg::OP_WRITE) begin
            last_rule_write[h.rule_slot] = h;
        end
        pending_items.push_back(h);
    endfunction

    function automatic void queue_rule(input ftpf_pkg::t_slot slot, input logic en,
                                       input logic dir, input logic [1:0] cls,
                                       input logic [31:0] sa, input logic [31:0] da,
                                       input logic [15:0] sp, input logic [15:0] dp,
                                       input logic sw, input logic dw);
        ftpf_pkg::t_in_item h;
        h = random_item();
        h.opcode        = ftpf_pkg::OP_WRITE;
        h.rule_slot     = slot;
        h.rule_enable   = en;
        h.direction     = dir;
        h.rule_class    = cls;
        h.src_addr      = sa;
        h.dst_addr      = da;
        h.src_port      = sp;
        h.dst_port      = dp;
        h.src_port_wild = sw;
        h.dst_port_wild = dw;
        queue_item(h);
    endfunction

    function automatic void queue_header(input logic dir, input logic [7:0] proto,
                                         input logic [31:0] sa, input logic [31:0] da,
                                         input logic [15:0] sp, input logic [15:0] dp);
        ftpf_pkg::t_in_item h;
        h = random_item();
        h.opcode      = ftpf_pkg::OP_CLASSIFY;
        h.direction   = dir;
        h.ip_protocol = proto;
        h.src_addr    = sa;
        h.dst_addr    = da;
        h.src_port    = sp;
        h.dst_port    = dp;
        queue_item(h);
    endfunction

    // Mostly headers aimed at stored rules, some rule writes, some raw noise
    function automatic void queue_random_items(input int count);
        ftpf_pkg::t_in_item h;
        ftpf_pkg::t_in_item r;
        int                 pick;
        for (int n = 0; n < count; n++) begin
            h = random_item();
            pick = $urandom_range(99);
            if (pick < 55) begin
                r = last_rule_write[$urandom_range(7)];
                h.opcode = ftpf_pkg::OP_CLASSIFY;
                h.direction = ($urandom_range(9) == 0) ? ~r.direction : r.direction;
                if ($urandom_range(9) != 0) begin
                    if (r.rule_class == ftpf_pkg::CLASS_TCP) begin
                        h.ip_protocol = ftpf_pkg::PROTO_TCP;
                    end else if (r.rule_class == ftpf_pkg::CLASS_UDP) begin
                        h.ip_protocol = ftpf_pkg::PROTO_UDP;
                    end else begin
                        h.ip_protocol = $urandom_range(1) ? ftpf_pkg::PROTO_UDP
                                                          : ftpf_pkg::PROTO_TCP;
                    end
                end
                case ($urandom_range(9))
                    0: h.src_addr = '0;
                    1: ;
                    default: h.src_addr = r.src_addr;
                endcase
                case ($urandom_range(9))
                    0: h.dst_addr = '0;
                    1: ;
                    default: h.dst_addr = r.dst_addr;
                endcase
                if ($urandom_range(99) < 85) h.src_port = r.src_port;
                if ($urandom_range(99) < 85) h.dst_port = r.dst_port;
            end else if (pick < 80) begin
                h.opcode = ftpf_pkg::OP_WRITE;
                h.rule_enable = ($urandom_range(9) != 0);
                h.rule_class = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2))
                                                        : 2'($urandom_range(1));
                if ($urandom_range(99) < 15) h.src_addr = '0;
                if ($urandom_range(99) < 15) h.dst_addr = '0;
            end
            queue_item(h);
        end
    endfunction

    // Driver: present queued items, hold while stalled, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_transfer(i_in);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in       <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge i_clk) begin : verdict_monitor
        ftpf_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got drop %0b hit_slot %0d",
                             $time, o_out.drop, o_out.hit_slot);
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_out.drop !== want.drop) begin
                        $display("%0t: drop mismatch, expected %0b, got %0b",
                                 $time, want.drop, o_out.drop);
                        mismatch_count++;
                    end
                    if (o_out.hit_slot !== want.hit_slot) begin
                        $display("%0t: hit_slot mismatch, expected %0d, got %0d",
                                 $time, want.hit_slot, o_out.hit_slot);
                        mismatch_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Hold until every queued item is sent and every result has come back
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || i_in_valid || expected_verdicts.size() != 0);
    endtask

    initial begin : stimulus
        for (int k = 0; k < ACL_DEPTH; k++) acl_rules[k] = '0;
        for (int k = 0; k < 8; k++) last_rule_write[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty set, exact and zero-address matches, direction and class
        // mismatches, disabled rule, unused classes, other protocols, priority
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'h0A00_0002, 32'h0A00_0001, 16'd1, 16'd2);
        queue_rule(3'd0, 1'b1, 1'b0, ftpf_pkg::CLASS_TCP, 32'hFFFF_FFFF, 32'h0A00_0001,
                   16'hFFFF, 16'h0000, 1'b0, 1'b0);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'hFFFF_FFFF, 32'h0A00_0001,
                     16'hFFFF, 16'h0000);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'h0000_0000, 32'h0A00_0001,
                     16'hFFFF, 16'h0000);
        queue_header(1'b1, ftpf_pkg::PROTO_TCP, 32'hFFFF_FFFF, 32'h0A00_0001,
                     16'hFFFF, 16'h0000);
        queue_header(1'b0, ftpf_pkg::PROTO_UDP, 32'hFFFF_FFFF, 32'h0A00_0001,
                     16'hFFFF, 16'h0000);
        queue_rule(3'd7, 1'b1, 1'b1, ftpf_pkg::CLASS_UDP, 32'h0, 32'h0, 16'h1234, 16'd80,
                   1'b1, 1'b0);
        queue_header(1'b1, ftpf_pkg::PROTO_UDP, 32'hC0A8_0101, 32'h0808_0808,
                     16'hABCD, 16'd80);
        queue_header(1'b1, ftpf_pkg::PROTO_UDP, 32'hC0A8_0101, 32'h0808_0808,
                     16'hABCD, 16'd81);
        queue_rule(3'd3, 1'b0, 1'b0, ftpf_pkg::CLASS_TCP, 32'h0, 32'h0, 16'h0, 16'h0,
                   1'b1, 1'b1);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'h0102_0304, 32'h0506_0708,
                     16'd1000, 16'd443);
        queue_rule(3'd4, 1'b1, 1'b0, 2'd2, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b1);
        queue_rule(3'd5, 1'b1, 1'b1, 2'd3, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 1'b1);
        queue_header(1'b0, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_header(1'b0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'h0102_0304, 32'h0506_0708,
                     16'd1000, 16'd443);
        queue_header(1'b1, ftpf_pkg::PROTO_UDP, 32'h0102_0304, 32'h0506_0708,
                     16'd1000, 16'd1234);
        queue_rule(3'd3, 1'b1, 1'b0, ftpf_pkg::CLASS_TCP, 32'h0, 32'h0, 16'h0, 16'h0,
                   1'b1, 1'b1);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'hFFFF_FFFF, 32'h0A00_0001,
                     16'hFFFF, 16'h0000);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'h0102_0304, 32'h0506_0708,
                     16'd1000, 16'd443);
        queue_rule(3'd1, 1'b1, 1'b0, ftpf_pkg::CLASS_TCP, 32'h1234_5678, 32'h0,
                   16'h0, 16'h0, 1'b1, 1'b1);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'h1234_5679, 32'hFFFF_FFFF, 16'd7, 16'd9);
        queue_header(1'b0, ftpf_pkg::PROTO_TCP, 32'h1234_5678, 32'hFFFF_FFFF, 16'd7, 16'd9);
        queue_header(1'b1, ftpf_pkg::PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'd80);

        // Sender idles rarely, receiver stalls often
        queue_random_items(640);
        drain();

        // Swap the idling sides
        send_gap_pct   = 85;
        recv_stall_pct = 10;
        queue_random_items(640);
        drain();

        // Full rate on both sides
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        queue_random_items(645);
        drain();

        repeat (24) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ five_tuple_rule_packet_filter.f @@
design/ftpf_pkg.sv
design/five_tuple_rule_packet_filter.sv
design/ftpf_checker.sv
dv/testbench.sv
